// ----- rtl/ira_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and codes of the interpreter integer ALU.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int DataWidth = 64;
  localparam int HalfWidth = DataWidth / 2;
  localparam int DivSteps  = DataWidth;

  typedef enum logic [4:0] {
    CmdNop  = 5'd0,
    CmdTrunc = 5'd1,
    CmdZext = 5'd2,
    CmdSext = 5'd3,
    CmdAdd  = 5'd4,
    CmdSub  = 5'd5,
    CmdMul  = 5'd6,
    CmdUdiv = 5'd7,
    CmdSdiv = 5'd8,
    CmdUrem = 5'd9,
    CmdSrem = 5'd10,
    CmdCmp  = 5'd11,
    CmdShl  = 5'd12,
    CmdShr  = 5'd13,
    CmdSar  = 5'd14,
    CmdAnd  = 5'd15,
    CmdOr   = 5'd16,
    CmdXor  = 5'd17
  } cmd_e;

  typedef enum logic [3:0] {
    CmpEq  = 4'd0,
    CmpNe  = 4'd1,
    CmpUgt = 4'd2,
    CmpUge = 4'd3,
    CmpUlt = 4'd4,
    CmpUle = 4'd5,
    CmpSgt = 4'd6,
    CmpSge = 4'd7,
    CmpSlt = 4'd8,
    CmpSle = 4'd9
  } cmp_e;

  typedef enum logic [1:0] {
    TruncBool = 2'd0,
    Trunc32   = 2'd1,
    TruncFull = 2'd2,
    TruncSpare = 2'd3
  } trunc_e;

  // Payload that travels down the divider chain.
  typedef struct packed {
    cmd_e                 op;
    logic [DataWidth-1:0] res;
    logic                 err;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] dvs;
  } pipe_t;

endpackage
`default_nettype wire

// ----- rtl/ir_integer_alu_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_integer_alu_top
// Pipelined 64-bit integer ALU of an intermediate-language interpreter.
// ----------------------------------------------------------------------------
// A request is taken in every cycle that start_i is high; busy_o stays low.
// Every request gives one result, marked by result_valid_o for a single
// cycle, whatever the operation. Its path is the restoring divider, one
// quotient bit per stage over 64 stages, plus an input stage, a
// partial-product stage, a sum and divider set-up stage and the output
// register. The receiver cannot stall the results.
module ir_integer_alu_top import ira_pkg::*; (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  wire  [4:0]           command_i,
  input  wire  [DataWidth-1:0] lhs_i,
  input  wire  [DataWidth-1:0] rhs_i,
  input  wire  [3:0]           compare_kind_i,
  input  wire  [1:0]           trunc_width_i,
  output logic                 result_valid_o,
  output logic [DataWidth-1:0] result_o,
  output logic                 divide_error_o
);

  // input stage
  logic                 s0_valid_q;
  cmd_e                 s0_cmd_q;
  logic [DataWidth-1:0] s0_a_q, s0_b_q;
  cmp_e                 s0_kind_q;
  trunc_e               s0_tw_q;

  // simple ops and partial products
  logic                 s1_valid_q;
  cmd_e                 s1_cmd_q;
  logic [DataWidth-1:0] s1_a_q, s1_b_q, s1_res_q, s1_res_d;
  logic [DataWidth-1:0] s1_ll_q;
  logic [HalfWidth-1:0] s1_lh_q, s1_hl_q;
  logic [DataWidth-1:0] s1_ll_d;
  logic [HalfWidth-1:0] s1_lh_d, s1_hl_d;

  logic                 chain_valid [0:DivSteps];
  pipe_t                chain       [0:DivSteps];
  logic                 s2_valid_q;
  pipe_t                s2_q, s2_d;

  logic                 out_valid_q, out_err_q;
  logic [DataWidth-1:0] out_res_q, out_res_d;
  logic                 cmp_bit;
  logic                 big_shift;
  logic                 is_div;
  logic [DataWidth-1:0] mag_a, mag_b;
  logic [DataWidth-1:0] mul_sum;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= start_i;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= chain_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    s0_cmd_q  <= cmd_e'(command_i);
    s0_a_q    <= lhs_i;
    s0_b_q    <= rhs_i;
    s0_kind_q <= cmp_e'(compare_kind_i);
    s0_tw_q   <= trunc_e'(trunc_width_i);
  end

  always_comb begin
    case (s0_kind_q)
      CmpEq:   cmp_bit = (s0_a_q == s0_b_q);
      CmpNe:   cmp_bit = (s0_a_q != s0_b_q);
      CmpUgt:  cmp_bit = (s0_a_q >  s0_b_q);
      CmpUge:  cmp_bit = (s0_a_q >= s0_b_q);
      CmpUlt:  cmp_bit = (s0_a_q <  s0_b_q);
      CmpUle:  cmp_bit = (s0_a_q <= s0_b_q);
      CmpSgt:  cmp_bit = ($signed(s0_a_q) >  $signed(s0_b_q));
      CmpSge:  cmp_bit = ($signed(s0_a_q) >= $signed(s0_b_q));
      CmpSlt:  cmp_bit = ($signed(s0_a_q) <  $signed(s0_b_q));
      CmpSle:  cmp_bit = ($signed(s0_a_q) <= $signed(s0_b_q));
      default: cmp_bit = 1'b0;
    endcase
  end

  assign big_shift = |s0_b_q[DataWidth-1:$clog2(DataWidth)];

  always_comb begin
    case (s0_cmd_q)
      CmdTrunc: begin
        case (s0_tw_q)
          TruncBool: s1_res_d = {{(DataWidth-1){1'b0}}, (s0_a_q != '0)};
          Trunc32:   s1_res_d = {{(DataWidth-32){1'b0}}, s0_a_q[31:0]};
          default:   s1_res_d = s0_a_q;
        endcase
      end
      CmdZext, CmdSext: s1_res_d = s0_a_q;
      CmdAdd:  s1_res_d = s0_a_q + s0_b_q;
      CmdSub:  s1_res_d = s0_a_q - s0_b_q;
      CmdCmp:  s1_res_d = {{(DataWidth-1){1'b0}}, cmp_bit};
      CmdShl:  s1_res_d = big_shift ? '0
                          : s0_a_q << s0_b_q[$clog2(DataWidth)-1:0];
      CmdShr:  s1_res_d = big_shift ? '0
                          : s0_a_q >> s0_b_q[$clog2(DataWidth)-1:0];
      CmdSar:  s1_res_d = big_shift ? {DataWidth{s0_a_q[DataWidth-1]}}
                          : DataWidth'($signed(s0_a_q) >>>
                                       s0_b_q[$clog2(DataWidth)-1:0]);
      CmdAnd:  s1_res_d = s0_a_q & s0_b_q;
      CmdOr:   s1_res_d = s0_a_q | s0_b_q;
      CmdXor:  s1_res_d = s0_a_q ^ s0_b_q;
      default: s1_res_d = '0;
    endcase
  end

  // low word of the product needs only three half-width products
  assign s1_ll_d = s0_a_q[HalfWidth-1:0] * s0_b_q[HalfWidth-1:0];
  assign s1_lh_d = s0_a_q[HalfWidth-1:0] * s0_b_q[DataWidth-1:HalfWidth];
  assign s1_hl_d = s0_a_q[DataWidth-1:HalfWidth] * s0_b_q[HalfWidth-1:0];

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= s0_cmd_q;
    s1_a_q   <= s0_a_q;
    s1_b_q   <= s0_b_q;
    s1_res_q <= s1_res_d;
    s1_ll_q  <= s1_ll_d;
    s1_lh_q  <= s1_lh_d;
    s1_hl_q  <= s1_hl_d;
  end

  assign mul_sum = s1_ll_q + {s1_lh_q + s1_hl_q, {HalfWidth{1'b0}}};

  always_comb begin
    is_div = (s1_cmd_q == CmdUdiv) || (s1_cmd_q == CmdSdiv) ||
             (s1_cmd_q == CmdUrem) || (s1_cmd_q == CmdSrem);
    mag_a  = s1_a_q[DataWidth-1] ? ('0 - s1_a_q) : s1_a_q;
    mag_b  = s1_b_q[DataWidth-1] ? ('0 - s1_b_q) : s1_b_q;
    s2_d       = '0;
    s2_d.op    = s1_cmd_q;
    s2_d.res   = (s1_cmd_q == CmdMul) ? mul_sum : s1_res_q;
    s2_d.err   = is_div && (s1_b_q == '0);
    s2_d.neg_q = s1_a_q[DataWidth-1] ^ s1_b_q[DataWidth-1];
    s2_d.neg_r = s1_a_q[DataWidth-1];
    if ((s1_cmd_q == CmdSdiv) || (s1_cmd_q == CmdSrem)) begin
      s2_d.quo = mag_a;
      s2_d.dvs = mag_b;
    end else begin
      s2_d.quo = s1_a_q;
      s2_d.dvs = s1_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  assign chain_valid[0] = s2_valid_q;
  assign chain[0]       = s2_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    ira_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .stage_i (chain[i]),
      .valid_o (chain_valid[i+1]),
      .stage_o (chain[i+1])
    );
  end

  always_comb begin
    case (chain[DivSteps].op)
      CmdUdiv: out_res_d = chain[DivSteps].quo;
      CmdUrem: out_res_d = chain[DivSteps].rem;
      CmdSdiv: out_res_d = chain[DivSteps].neg_q ? ('0 - chain[DivSteps].quo)
                                                 : chain[DivSteps].quo;
      CmdSrem: out_res_d = chain[DivSteps].neg_r ? ('0 - chain[DivSteps].rem)
                                                 : chain[DivSteps].rem;
      default: out_res_d = chain[DivSteps].res;
    endcase
    // zero divisor: force the quotient or remainder to zero
    if (chain[DivSteps].err) begin
      out_res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_err_q <= 1'b0;
    end else begin
      out_err_q <= chain_valid[DivSteps] && chain[DivSteps].err;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_res_q;
  assign divide_error_o = out_err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    divide_error_o |-> (result_o == '0))
    else $error("divide error with non-zero result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    divide_error_o |-> result_valid_o)
    else $error("divide error without a result strobe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[DivSteps] && chain[DivSteps].err) |=> divide_error_o)
    else $error("zero divisor lost at the output");

endmodule
`default_nettype wire

// ----- rtl/ira_div_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ira_div_step
// One registered step of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module ira_div_step import ira_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   valid_i,
  input  pipe_t stage_i,
  output logic  valid_o,
  output pipe_t stage_o
);

  logic          valid_q;
  pipe_t         stage_q;
  pipe_t         stage_d;
  logic [DataWidth:0] trial;
  logic [DataWidth:0] diff;

  always_comb begin
    trial   = {stage_i.rem, stage_i.quo[DataWidth-1]};
    diff    = trial - {1'b0, stage_i.dvs};
    stage_d = stage_i;
    if (!diff[DataWidth]) begin
      stage_d.rem = diff[DataWidth-1:0];
      stage_d.quo = {stage_i.quo[DataWidth-2:0], 1'b1};
    end else begin
      stage_d.rem = trial[DataWidth-1:0];
      stage_d.quo = {stage_i.quo[DataWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

  // The partial remainder stays below a non-zero divisor after every step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && stage_q.dvs != '0) |-> (stage_q.rem < stage_q.dvs))
    else $error("partial remainder not below divisor");

endmodule
`default_nettype wire
